FILE: hdl/plst_pkg.sv
// shared constants, codes and control types for the positional list store
package plst_pkg;

  localparam int DEPTH      = 64;
  localparam int VALUE_BITS = 32;
  localparam int IDX_W      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W      = $clog2(DEPTH + 1);
  localparam int CMD_W      = 3;
  localparam int POS_W      = 8;
  localparam int STAT_W     = 2;
  localparam int CMP_W      = (CNT_W > POS_W) ? CNT_W : POS_W;

  // stream payload layout
  localparam int IN_BITS   = CMD_W + POS_W + VALUE_BITS;
  localparam int IN_DATA_W = ((IN_BITS + 7) / 8) * 8;
  localparam int IN_CMD_LO = 0;
  localparam int IN_POS_LO = CMD_W;
  localparam int IN_VAL_LO = CMD_W + POS_W;

  localparam int OUT_BITS    = VALUE_BITS + STAT_W + CNT_W;
  localparam int OUT_DATA_W  = ((OUT_BITS + 7) / 8) * 8;
  localparam int OUT_VAL_LO  = 0;
  localparam int OUT_STAT_LO = VALUE_BITS;
  localparam int OUT_LEN_LO  = VALUE_BITS + STAT_W;

  localparam logic [CMD_W-1:0] CMD_GET      = 3'd0;
  localparam logic [CMD_W-1:0] CMD_INS_HEAD = 3'd1;
  localparam logic [CMD_W-1:0] CMD_APPEND   = 3'd2;
  localparam logic [CMD_W-1:0] CMD_INS_AT   = 3'd3;
  localparam logic [CMD_W-1:0] CMD_DELETE   = 3'd4;

  localparam logic [STAT_W-1:0] ST_DONE    = 2'd0;
  localparam logic [STAT_W-1:0] ST_INVALID = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL    = 2'd2;

  typedef struct packed {
    logic             ins;
    logic             del;
    logic [CMP_W-1:0] pos;
  } cell_ctl_t;

endpackage

FILE: hdl/plst_cell.sv
// one list slot: holds an entry and shifts from its neighbors on insert or delete
module plst_cell
  import plst_pkg::*;
(
  input  logic                  clk,
  input  logic [IDX_W-1:0]      idx,
  input  cell_ctl_t             ctl,
  input  logic [VALUE_BITS-1:0] new_value,
  input  logic [VALUE_BITS-1:0] lower_value,
  input  logic [VALUE_BITS-1:0] upper_value,
  output logic [VALUE_BITS-1:0] value,
  output logic [VALUE_BITS-1:0] read_data
);

  logic [CMP_W-1:0] my_idx;

  assign my_idx = CMP_W'(idx);

  always_ff @(posedge clk) begin
    if (ctl.ins) begin
      if (my_idx > ctl.pos) begin
        value <= lower_value;
      end else if (my_idx == ctl.pos) begin
        value <= new_value;
      end
    end else if (ctl.del && my_idx >= ctl.pos) begin
      value <= upper_value;
    end
  end

  // zero unless this slot is addressed, so the top can or all slots together
  assign read_data = (my_idx == ctl.pos) ? value : '0;

endmodule

FILE: hdl/positional_list_store.sv
// top level: command decode, row of list cells and registered result
//
// Ordered list of up to DEPTH signed values kept in a row of cells, each cell
// holding one entry and loading from its lower neighbor on insert or from its
// upper neighbor on delete. The commands are get, insert at head, append,
// insert before position and delete at position; the result sits in an
// output register, and a new transaction is taken in the same cycle the
// previous result is taken, so one item per cycle is sustained while the
// consumer keeps tready high. Each item gives exactly one result carrying the
// read value (all ones unless a get succeeded), a status (done, position
// invalid, store full) and the length after the item. No clearing is needed
// after reset: only entries below the length can be read.
module positional_list_store
  import plst_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [IN_DATA_W-1:0]  s_tdata,  // cmd, position, item_value, zero pad
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [OUT_DATA_W-1:0] m_tdata   // read_value, status, length, zero pad
);

  logic [CNT_W-1:0]      count;
  logic [CNT_W-1:0]      count_next;
  logic [VALUE_BITS-1:0] read_value;
  logic [STAT_W-1:0]     status;

  logic                  accept;
  logic [CMD_W-1:0]      cmd;
  logic [CMP_W-1:0]      position;
  logic [VALUE_BITS-1:0] item_value;
  logic [CMP_W-1:0]      count_ext;
  logic                  full;
  logic                  get_ok;
  logic [STAT_W-1:0]     status_next;
  cell_ctl_t             ctl;

  logic [VALUE_BITS-1:0] cell_value [DEPTH];
  logic [VALUE_BITS-1:0] cell_read  [DEPTH];
  logic [VALUE_BITS-1:0] lower_val  [DEPTH];
  logic [VALUE_BITS-1:0] upper_val  [DEPTH];
  logic [VALUE_BITS-1:0] read_or;

  assign s_tready   = !m_tvalid || m_tready;
  assign accept     = s_tvalid && s_tready;
  assign cmd        = s_tdata[IN_CMD_LO +: CMD_W];
  assign position   = CMP_W'(s_tdata[IN_POS_LO +: POS_W]);
  assign item_value = s_tdata[IN_VAL_LO +: VALUE_BITS];
  assign count_ext  = CMP_W'(count);
  assign full       = (count == CNT_W'(DEPTH));

  always_comb begin
    ctl         = '0;
    ctl.pos     = position;
    get_ok      = 1'b0;
    status_next = ST_DONE;
    count_next  = count;
    case (cmd)
      CMD_GET: begin
        if (position < count_ext) begin
          get_ok = 1'b1;
        end else begin
          status_next = ST_INVALID;
        end
      end
      CMD_INS_HEAD: begin
        ctl.pos = '0;
        if (full) begin
          status_next = ST_FULL;
        end else begin
          ctl.ins    = accept;
          count_next = count + 1'b1;
        end
      end
      CMD_APPEND: begin
        ctl.pos = count_ext;
        if (full) begin
          status_next = ST_FULL;
        end else begin
          ctl.ins    = accept;
          count_next = count + 1'b1;
        end
      end
      CMD_INS_AT: begin
        if (position > count_ext) begin
          status_next = ST_INVALID;
        end else if (full) begin
          status_next = ST_FULL;
        end else begin
          ctl.ins    = accept;
          count_next = count + 1'b1;
        end
      end
      CMD_DELETE: begin
        if (position < count_ext) begin
          ctl.del    = accept;
          count_next = count - 1'b1;
        end else begin
          status_next = ST_INVALID;
        end
      end
      default: begin
        status_next = ST_INVALID;
      end
    endcase
  end

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    if (i == 0) begin : g_first
      assign lower_val[i] = cell_value[i];
    end else begin : g_lower
      assign lower_val[i] = cell_value[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign upper_val[i] = cell_value[i];
    end else begin : g_upper
      assign upper_val[i] = cell_value[i+1];
    end

    plst_cell u_cell (
      .clk         (clk),
      .idx         (IDX_W'(i)),
      .ctl         (ctl),
      .new_value   (item_value),
      .lower_value (lower_val[i]),
      .upper_value (upper_val[i]),
      .value       (cell_value[i]),
      .read_data   (cell_read[i])
    );
  end

  always_comb begin
    read_or = '0;
    for (int i = 0; i < DEPTH; i++) begin
      read_or = read_or | cell_read[i];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count    <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (accept) begin
        count    <= count_next;
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      read_value <= get_ok ? read_or : '1;
      status     <= status_next;
    end
  end

  always_comb begin
    m_tdata = '0;
    m_tdata[OUT_VAL_LO +: VALUE_BITS] = read_value;
    m_tdata[OUT_STAT_LO +: STAT_W]    = status;
    m_tdata[OUT_LEN_LO +: CNT_W]      = count;
  end

endmodule

FILE: hdl/plst_checker.sv
// port-level checks for the positional list store, bound to the top level
module plst_checker
  import plst_pkg::*;
(
  input logic                  clk,
  input logic                  rst,
  input logic                  s_tvalid,
  input logic                  s_tready,
  input logic                  m_tvalid,
  input logic                  m_tready,
  input logic [OUT_DATA_W-1:0] m_tdata
);

  logic [VALUE_BITS-1:0] read_value;
  logic [STAT_W-1:0]     status;
  logic [CNT_W-1:0]      length;

  assign read_value = m_tdata[OUT_VAL_LO +: VALUE_BITS];
  assign status     = m_tdata[OUT_STAT_LO +: STAT_W];
  assign length     = m_tdata[OUT_LEN_LO +: CNT_W];

  // a stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result changed while stalled");

  // every input transaction yields a result in the next cycle
  a_result: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> m_tvalid)
    else $error("no result after input transaction");

  a_len: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> length <= CNT_W'(DEPTH))
    else $error("length beyond depth");

  a_full: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && status == ST_FULL |-> length == CNT_W'(DEPTH))
    else $error("full status with room left");

  a_fail_value: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && status != ST_DONE |-> read_value == '1)
    else $error("failed command returned a value");

endmodule

bind positional_list_store plst_checker u_plst_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
